// ----- hdl/lap_pkg.sv -----
// ----------------------------------------------------------------------------
// lap_pkg
// Shared types, constants and helper functions for the 2-D Laplacian unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lap_pkg;

  // Default grid limits
  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  // Field and internal widths
  localparam int SIZE_W     = 9;
  localparam int POS_W      = 13;
  localparam int SCALE_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int LAP_W      = 32;
  localparam int ACC_W      = 23;
  localparam int WT_W       = 6;
  localparam int PROD_W     = ACC_W + SCALE_W + 1;
  localparam int FRAC_W     = 8;
  localparam int TAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_SIZE   = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_X   = 3'd5;

  // Command and status codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;
  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_RANGE  = 1'b1;

  // Last tap of each stencil
  localparam logic [TAP_W-1:0] TAP_LAST_CENTER = 3'd4;
  localparam logic [TAP_W-1:0] TAP_LAST_EDGE   = 3'd2;

  // Saturation limits
  localparam logic signed [LAP_W-1:0] LAP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [LAP_W-1:0] LAP_MIN = 32'sh8000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic             capture;
    logic             wr_en;
    logic             rd_en;
    logic             axis_x;
    logic [TAP_W-1:0] tap;
    logic             acc_clear;
    logic             mul_en;
    logic             sum_en;
    logic             err_en;
    logic             out_load;
  } lap_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_compute;
    logic in_range;
    logic center_z;
    logic center_x;
  } lap_stat_t;

  // Stencil weight of one tap
  function automatic logic signed [WT_W-1:0] tap_weight(input logic center,
                                                       input logic [TAP_W-1:0] tap);
    logic signed [WT_W-1:0] w;
    w = '0;
    if (center) begin
      case (tap)
        3'd0:    w = -6'sd1;
        3'd1:    w = 6'sd16;
        3'd2:    w = -6'sd30;
        3'd3:    w = 6'sd16;
        3'd4:    w = -6'sd1;
        default: w = '0;
      endcase
    end else begin
      case (tap)
        3'd0:    w = 6'sd1;
        3'd1:    w = -6'sd2;
        3'd2:    w = 6'sd1;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

  // Clamp a size register to [MIN_SIZE, maxv]
  function automatic logic [POS_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input int maxv);
    logic [POS_W-1:0] r;
    r = POS_W'(v);
    if (r > POS_W'(maxv)) r = POS_W'(maxv);
    if (r < POS_W'(MIN_SIZE)) r = POS_W'(MIN_SIZE);
    return r;
  endfunction

endpackage

// ----- hdl/lap_dp.sv -----
// ----------------------------------------------------------------------------
// lap_dp
// Datapath: configuration registers, grid memory, tap addressing, stencil
// accumulators, scaling multipliers, saturation and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap_dp #(
  parameter int MAX_ROWS = lap_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lap_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [lap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lap_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   command,
  input  logic [7:0]                             row,
  input  logic [7:0]                             col,
  input  logic signed [lap_pkg::SAMPLE_W-1:0]    sample,
  input  lap_pkg::lap_cmd_t                      cmd,
  output lap_pkg::lap_stat_t                     stat,
  output logic signed [lap_pkg::LAP_W-1:0]       lap_value,
  output logic                                   status
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Configuration registers
  logic [lap_pkg::SIZE_W-1:0]  rows_in_use;
  logic [lap_pkg::SIZE_W-1:0]  cols_in_use;
  logic [lap_pkg::SCALE_W-1:0] center_z_scale;
  logic [lap_pkg::SCALE_W-1:0] edge_z_scale;
  logic [lap_pkg::SCALE_W-1:0] center_x_scale;
  logic [lap_pkg::SCALE_W-1:0] edge_x_scale;

  // Captured item
  logic                                command_q;
  logic [7:0]                          row_q;
  logic [7:0]                          col_q;
  logic signed [lap_pkg::SAMPLE_W-1:0] sample_q;

  // Geometry
  logic [lap_pkg::POS_W-1:0] nz, nx, pos_z, pos_x, base_z, base_x, tap_idx;
  logic [lap_pkg::POS_W-1:0] rd_row, rd_col;
  logic                      center_z, center_x;
  logic [ADDR_W-1:0]         addr;

  // Memory and accumulation
  logic signed [lap_pkg::SAMPLE_W-1:0] grid_mem [DEPTH];
  logic signed [lap_pkg::SAMPLE_W-1:0] rd_data;
  logic                                acc_en;
  logic                                acc_axis;
  logic [lap_pkg::TAP_W-1:0]           acc_tap;
  logic signed [lap_pkg::WT_W-1:0]     wt;
  logic signed [lap_pkg::ACC_W-1:0]    rd_ext, wterm;
  logic signed [lap_pkg::ACC_W-1:0]    acc_z, acc_x;

  // Scaling and result
  logic signed [lap_pkg::SCALE_W:0]    scale_z, scale_x;
  logic signed [lap_pkg::PROD_W-1:0]   prod_z, prod_x;
  logic signed [lap_pkg::LAP_W-1:0]    term_z, term_x;
  logic signed [lap_pkg::LAP_W:0]      total;
  logic signed [lap_pkg::LAP_W-1:0]    total_sat;
  logic signed [lap_pkg::LAP_W-1:0]    res_lap;
  logic                                res_err;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use    <= lap_pkg::SIZE_W'(256);
      cols_in_use    <= lap_pkg::SIZE_W'(256);
      center_z_scale <= '0;
      edge_z_scale   <= '0;
      center_x_scale <= '0;
      edge_x_scale   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lap_pkg::REG_ROWS:     rows_in_use    <= cfg_data[lap_pkg::SIZE_W-1:0];
        lap_pkg::REG_COLS:     cols_in_use    <= cfg_data[lap_pkg::SIZE_W-1:0];
        lap_pkg::REG_CENTER_Z: center_z_scale <= cfg_data;
        lap_pkg::REG_EDGE_Z:   edge_z_scale   <= cfg_data;
        lap_pkg::REG_CENTER_X: center_x_scale <= cfg_data;
        lap_pkg::REG_EDGE_X:   edge_x_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      command_q <= command;
      row_q     <= row;
      col_q     <= col;
      sample_q  <= sample;
    end
  end

  // Grid size, stencil choice and first tap of each axis
  always_comb begin
    nz       = lap_pkg::clamp_size(rows_in_use, MAX_ROWS);
    nx       = lap_pkg::clamp_size(cols_in_use, MAX_COLS);
    pos_z    = lap_pkg::POS_W'(row_q);
    pos_x    = lap_pkg::POS_W'(col_q);
    center_z = (pos_z >= lap_pkg::POS_W'(2)) && (pos_z + lap_pkg::POS_W'(2) < nz);
    center_x = (pos_x >= lap_pkg::POS_W'(2)) && (pos_x + lap_pkg::POS_W'(2) < nx);
    if (center_z) base_z = pos_z - lap_pkg::POS_W'(2);
    else if (pos_z < lap_pkg::POS_W'(2)) base_z = '0;
    else base_z = nz - lap_pkg::POS_W'(3);
    if (center_x) base_x = pos_x - lap_pkg::POS_W'(2);
    else if (pos_x < lap_pkg::POS_W'(2)) base_x = '0;
    else base_x = nx - lap_pkg::POS_W'(3);
  end

  assign stat.is_compute = (command_q == lap_pkg::CMD_COMPUTE);
  assign stat.in_range   = (pos_z < nz) && (pos_x < nx);
  assign stat.center_z   = center_z;
  assign stat.center_x   = center_x;

  // Memory address: the item's point for a write, a stencil tap for a read
  always_comb begin
    tap_idx = (cmd.axis_x ? base_x : base_z) + lap_pkg::POS_W'(cmd.tap);
    rd_row  = (cmd.axis_x || cmd.wr_en) ? pos_z : tap_idx;
    rd_col  = (cmd.axis_x && !cmd.wr_en) ? tap_idx : pos_x;
    addr    = ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);
  end

  // Single-port grid memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      grid_mem[addr] <= sample_q;
    end else if (cmd.rd_en) begin
      rd_data <= grid_mem[addr];
    end
  end

  // Track which tap the read data belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    acc_axis <= cmd.axis_x;
    acc_tap  <= cmd.tap;
  end

  // Weight the returned sample
  always_comb begin
    wt     = lap_pkg::tap_weight(acc_axis ? center_x : center_z, acc_tap);
    rd_ext = lap_pkg::ACC_W'(rd_data);
    wterm  = rd_ext * lap_pkg::ACC_W'(wt);
  end

  // Accumulate the stencil sums
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_z <= '0;
      acc_x <= '0;
    end else if (acc_en) begin
      if (acc_axis) acc_x <= acc_x + wterm;
      else          acc_z <= acc_z + wterm;
    end
  end

  // Scale both axis sums
  assign scale_z = $signed({1'b0, center_z ? center_z_scale : edge_z_scale});
  assign scale_x = $signed({1'b0, center_x ? center_x_scale : edge_x_scale});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_z <= acc_z * scale_z;
      prod_x <= acc_x * scale_x;
    end
  end

  // Drop the fraction (floor), add and saturate
  always_comb begin
    term_z = prod_z[lap_pkg::PROD_W-1:lap_pkg::FRAC_W];
    term_x = prod_x[lap_pkg::PROD_W-1:lap_pkg::FRAC_W];
    total  = (lap_pkg::LAP_W+1)'(term_z) + (lap_pkg::LAP_W+1)'(term_x);
    if (total[lap_pkg::LAP_W] != total[lap_pkg::LAP_W-1]) begin
      total_sat = total[lap_pkg::LAP_W] ? lap_pkg::LAP_MIN : lap_pkg::LAP_MAX;
    end else begin
      total_sat = total[lap_pkg::LAP_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      res_lap <= total_sat;
      res_err <= lap_pkg::STAT_OK;
    end else if (cmd.err_en) begin
      res_lap <= '0;
      res_err <= lap_pkg::STAT_RANGE;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lap_value <= res_lap;
      status    <= res_err;
    end
  end

endmodule

// ----- hdl/lap_ctrl.sv -----
// ----------------------------------------------------------------------------
// lap_ctrl
// Controller: sequences loads, tap reads, scaling and result hand-off, and
// owns both channel handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lap_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lap_pkg::lap_stat_t stat,
  output lap_pkg::lap_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RD_Z   = 3'd2;
  localparam logic [2:0] S_RD_X   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_SUM    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]                state, state_next;
  logic [lap_pkg::TAP_W-1:0] tap, tap_next;
  logic                      last_z, last_x, out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign last_z   = (tap == (stat.center_z ? lap_pkg::TAP_LAST_CENTER
                                           : lap_pkg::TAP_LAST_EDGE));
  assign last_x   = (tap == (stat.center_x ? lap_pkg::TAP_LAST_CENTER
                                           : lap_pkg::TAP_LAST_EDGE));

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    tap_next   = tap;
    cmd        = '0;
    cmd.tap    = tap;
    case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        tap_next = '0;
        if (!stat.is_compute) begin
          cmd.wr_en  = stat.in_range;
          state_next = S_IDLE;
        end else if (stat.in_range) begin
          cmd.acc_clear = 1'b1;
          state_next    = S_RD_Z;
        end else begin
          cmd.err_en = 1'b1;
          state_next = S_OUT;
        end
      end
      S_RD_Z: begin
        cmd.rd_en = 1'b1;
        if (last_z) begin
          tap_next   = '0;
          state_next = S_RD_X;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      S_RD_X: begin
        cmd.rd_en  = 1'b1;
        cmd.axis_x = 1'b1;
        if (last_x) begin
          tap_next   = '0;
          state_next = S_DRAIN;
        end else begin
          tap_next = tap + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over a pending transaction");

  // A loaded result is presented on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // Z tap counter stays within the chosen stencil
  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_Z) |-> (tap <= (stat.center_z ? lap_pkg::TAP_LAST_CENTER
                                                 : lap_pkg::TAP_LAST_EDGE)))
    else $error("z tap beyond stencil");

  // Multiply only after the last tap has been accumulated
  a_mul_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> ($past(state) == S_DRAIN))
    else $error("scaling before the last tap settled");

endmodule

// ----- hdl/laplacian_stencil_2d_unit.sv -----
// ----------------------------------------------------------------------------
// laplacian_stencil_2d_unit
// Fourth-order 2-D Laplacian over a stored wavefield grid. A load transaction
// writes one signed sample at (row, col) and returns nothing; a compute
// transaction returns the saturated sum of the z and x stencil terms, or zero
// with status set when the point lies outside the rows and columns in use.
// All taps come from one single-port grid memory read one sample a cycle, and
// that port sets the rate. Each transaction ends before the next is taken: a
// compute decodes, reads 3 or 5 taps per axis, drains, scales, sums and hands
// off once any earlier result is taken; an out-of-range compute goes straight
// to hand-off and a load ends in decode. A finished result waits in the output
// register while the next transaction is taken. The grid holds no reset value:
// read only points already written. The configuration port takes a write each cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplacian_stencil_2d_unit #(
  parameter int MAX_ROWS = lap_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lap_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lap_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lap_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [7:0]                          row,
  input  logic [7:0]                          col,
  input  logic signed [lap_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lap_pkg::LAP_W-1:0]    lap_value,
  output logic                                status
);

  lap_pkg::lap_cmd_t  dp_cmd;
  lap_pkg::lap_stat_t dp_stat;

  // Configuration registers take every write
  assign cfg_ready = 1'b1;

  lap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  lap_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .command   (command),
    .row       (row),
    .col       (col),
    .sample    (sample),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .lap_value (lap_value),
    .status    (status)
  );

endmodule
